[rtl/tsa_pkg.sv]
// Shared types, constants and microcode ROM for the task slot allocator.
package tsa_pkg;

  localparam int SLOTS = 8;
  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int ID_W  = 32;
  localparam int SLOT_W = 3;

  localparam logic [SW-1:0] SLOT_MAX = SW'(SLOTS - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(SLOTS);

  localparam logic REQ_CREATE = 1'b0;
  localparam logic REQ_END    = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [ID_W-1:0] task_id;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   assigned_id;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WAIT,
    OP_POP,
    OP_ALLOC,
    OP_SCAN0,
    OP_SCAN,
    OP_FREE,
    OP_FAIL
  } op_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_ACC,
    J_END,
    J_EMPTY,
    J_SCAN
  } jmp_t;

  localparam int UPC_W = 3;

  typedef struct packed {
    op_t              op;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
  } uword_t;

  // microcode addresses
  localparam logic [UPC_W-1:0] U_WAIT  = 3'd0;
  localparam logic [UPC_W-1:0] U_DISP  = 3'd1;
  localparam logic [UPC_W-1:0] U_POP   = 3'd2;
  localparam logic [UPC_W-1:0] U_ALLOC = 3'd3;
  localparam logic [UPC_W-1:0] U_SCAN0 = 3'd4;
  localparam logic [UPC_W-1:0] U_SCAN  = 3'd5;
  localparam logic [UPC_W-1:0] U_FREE  = 3'd6;
  localparam logic [UPC_W-1:0] U_FAIL  = 3'd7;

  // sequencer -> datapath
  typedef struct packed {
    op_t  op;
    logic en;
  } ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic          accept;
    logic          is_end;
    logic          empty;
    logic          match;
    logic          last;
    logic          out_busy;
    logic [CW-1:0] count;
  } stat_t;

  // J_SCAN: match goes to target, miss on last slot goes to target + 1
  function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
    uword_t w;
    unique case (upc)
      U_WAIT:  w = '{op: OP_WAIT,  jmp: J_ACC,    target: U_DISP};
      U_DISP:  w = '{op: OP_NOP,   jmp: J_END,    target: U_SCAN0};
      U_POP:   w = '{op: OP_POP,   jmp: J_EMPTY,  target: U_FAIL};
      U_ALLOC: w = '{op: OP_ALLOC, jmp: J_ALWAYS, target: U_WAIT};
      U_SCAN0: w = '{op: OP_SCAN0, jmp: J_NEXT,   target: U_WAIT};
      U_SCAN:  w = '{op: OP_SCAN,  jmp: J_SCAN,   target: U_FREE};
      U_FREE:  w = '{op: OP_FREE,  jmp: J_ALWAYS, target: U_WAIT};
      U_FAIL:  w = '{op: OP_FAIL,  jmp: J_ALWAYS, target: U_WAIT};
      default: w = '{op: OP_NOP,   jmp: J_ALWAYS, target: U_WAIT};
    endcase
    return w;
  endfunction

  // slot index reported modulo 8
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SW-1:0] idx);
    logic [SW+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

[rtl/task_slot_allocator.sv]
// Task slot allocator top level: microcode sequencer driving the slot datapath.
// One item at a time: a new item can be taken in the cycle after the result is loaded;
// result steps hold while the output register is full. End requests are the slower
// path, set by the end scan: one slot compare per cycle on the id RAM.
// Reset (rst_n, synchronous): all slots dead, stack full, id counter 0; no clear pass.
module task_slot_allocator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsa_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output tsa_pkg::out_item_t out_item
);

  tsa_pkg::ctrl_t ctrl;
  tsa_pkg::stat_t stat;

  // Program: wait for an item, dispatch on request type.
  // Create: pop the free stack (fail when empty), then allocate and report.
  // End: prime the id RAM read at slot 0, compare one slot per cycle in
  // ascending order, then free the first live hit or report failure.
  // Result steps hold while the output register still holds an untaken item.
  tsa_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Datapath: the free stack lives in a RAM whose untouched entries are
  // served from the reset pattern by a low-water mark; alive bits are flops.
  tsa_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // free stack depth stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= tsa_pkg::COUNT_FULL)
    else $error("free stack count out of range");

  // one item in flight: no new item right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in flight");

  // a new result only comes from an executed result step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(ctrl.en) &&
      ($past(ctrl.op) == tsa_pkg::OP_ALLOC || $past(ctrl.op) == tsa_pkg::OP_FREE ||
       $past(ctrl.op) == tsa_pkg::OP_FAIL)))
    else $error("result raised without a result step");

endmodule

[rtl/tsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/tsa_useq.sv]
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
module tsa_useq (
  input  logic          clk,
  input  logic          rst_n,
  input  tsa_pkg::stat_t stat,
  output tsa_pkg::ctrl_t ctrl
);

  logic [tsa_pkg::UPC_W-1:0] upc_r, upc_nxt;
  tsa_pkg::uword_t           uw;
  logic                      result_op;
  logic                      en;

  assign uw = tsa_pkg::ucode(upc_r);

  // result steps stall while the output register is still full
  assign result_op = (uw.op == tsa_pkg::OP_ALLOC) || (uw.op == tsa_pkg::OP_FREE) ||
                     (uw.op == tsa_pkg::OP_FAIL);
  assign en = !(result_op && stat.out_busy);

  assign ctrl.op = uw.op;
  assign ctrl.en = en;

  always_comb begin
    upc_nxt = upc_r;
    if (en) begin
      unique case (uw.jmp)
        tsa_pkg::J_NEXT:   upc_nxt = upc_r + 1'b1;
        tsa_pkg::J_ALWAYS: upc_nxt = uw.target;
        tsa_pkg::J_ACC:    upc_nxt = stat.accept ? uw.target : upc_r;
        tsa_pkg::J_END:    upc_nxt = stat.is_end ? uw.target : upc_r + 1'b1;
        tsa_pkg::J_EMPTY:  upc_nxt = stat.empty ? uw.target : upc_r + 1'b1;
        tsa_pkg::J_SCAN: begin
          if (stat.match) begin
            upc_nxt = uw.target;
          end else if (stat.last) begin
            upc_nxt = uw.target + 1'b1;
          end else begin
            upc_nxt = upc_r;
          end
        end
        default:           upc_nxt = tsa_pkg::U_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= tsa_pkg::U_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

[rtl/tsa_dpath.sv]
// Datapath: request latch, id counter, free stack, slot table, result register.
module tsa_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  tsa_pkg::ctrl_t     ctrl,
  output tsa_pkg::stat_t     stat,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsa_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output tsa_pkg::out_item_t out_item
);

  logic                      req_r;
  logic [tsa_pkg::ID_W-1:0]  tid_r;
  logic [tsa_pkg::ID_W-1:0]  next_id_r;
  logic [tsa_pkg::CW-1:0]    count_r;
  logic [tsa_pkg::CW-1:0]    lw_r;     // lowest stack depth ever popped to
  logic [tsa_pkg::SW-1:0]    idx_r;
  logic [tsa_pkg::SLOTS-1:0] alive_r;
  logic                      out_valid_r;
  tsa_pkg::out_item_t        out_item_r;

  logic                      accept;
  logic                      exec_alloc, exec_free, exec_fail;
  logic [tsa_pkg::CW-1:0]    top_pos;
  logic                      pop_fresh;
  logic [tsa_pkg::SW-1:0]    fresh_val;
  logic [tsa_pkg::SW-1:0]    popped;
  logic [tsa_pkg::SW-1:0]    stk_rdata;
  logic [tsa_pkg::ID_W-1:0]  ids_rdata;
  logic                      stk_we, stk_re, ids_we, ids_re;
  logic [tsa_pkg::SW-1:0]    ids_raddr;

  assign in_ready = (ctrl.op == tsa_pkg::OP_WAIT);
  assign accept   = in_valid && in_ready;

  assign exec_alloc = ctrl.en && (ctrl.op == tsa_pkg::OP_ALLOC);
  assign exec_free  = ctrl.en && (ctrl.op == tsa_pkg::OP_FREE);
  assign exec_fail  = ctrl.en && (ctrl.op == tsa_pkg::OP_FAIL);

  // stack entries below the low-water mark were never touched: reset pattern
  assign top_pos   = count_r - 1'b1;
  assign pop_fresh = top_pos < lw_r;
  assign fresh_val = tsa_pkg::SLOT_MAX - top_pos[tsa_pkg::SW-1:0];
  assign popped    = pop_fresh ? fresh_val : stk_rdata;

  assign stk_re = (ctrl.op == tsa_pkg::OP_POP) && (count_r != '0);
  assign stk_we = exec_free && (count_r < tsa_pkg::COUNT_FULL);

  assign ids_re    = (ctrl.op == tsa_pkg::OP_SCAN0) || (ctrl.op == tsa_pkg::OP_SCAN);
  assign ids_raddr = (ctrl.op == tsa_pkg::OP_SCAN0) ? '0 : tsa_pkg::SW'(idx_r + 1'b1);
  assign ids_we    = exec_alloc;

  tsa_ram #(.WIDTH(tsa_pkg::SW), .DEPTH(tsa_pkg::SLOTS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (count_r[tsa_pkg::SW-1:0]),
    .wdata (idx_r),
    .re    (stk_re),
    .raddr (top_pos[tsa_pkg::SW-1:0]),
    .rdata (stk_rdata)
  );

  tsa_ram #(.WIDTH(tsa_pkg::ID_W), .DEPTH(tsa_pkg::SLOTS)) u_ids_ram (
    .clk   (clk),
    .we    (ids_we),
    .waddr (popped),
    .wdata (next_id_r),
    .re    (ids_re),
    .raddr (ids_raddr),
    .rdata (ids_rdata)
  );

  assign stat.accept   = accept;
  assign stat.is_end   = (req_r == tsa_pkg::REQ_END);
  assign stat.empty    = (count_r == '0);
  assign stat.match    = alive_r[idx_r] && (ids_rdata == tid_r);
  assign stat.last     = (idx_r == tsa_pkg::SLOT_MAX);
  assign stat.out_busy = out_valid_r && !out_ready;
  assign stat.count    = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r       <= tsa_pkg::REQ_CREATE;
      next_id_r   <= '0;
      count_r     <= tsa_pkg::COUNT_FULL;
      lw_r        <= tsa_pkg::COUNT_FULL;
      idx_r       <= '0;
      alive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        req_r <= in_item.req_type;
      end
      if (ctrl.op == tsa_pkg::OP_SCAN0) begin
        idx_r <= '0;
      end else if ((ctrl.op == tsa_pkg::OP_SCAN) && !stat.match) begin
        idx_r <= tsa_pkg::SW'(idx_r + 1'b1);
      end
      if (exec_alloc) begin
        next_id_r       <= next_id_r + 1'b1;
        count_r         <= top_pos;
        alive_r[popped] <= 1'b1;
        if (pop_fresh) begin
          lw_r <= top_pos;
        end
      end
      if (exec_free) begin
        alive_r[idx_r] <= 1'b0;
        if (count_r < tsa_pkg::COUNT_FULL) begin
          count_r <= count_r + 1'b1;
        end
      end
      if (exec_alloc || exec_free || exec_fail) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tid_r <= in_item.task_id;
    end
    if (exec_alloc) begin
      out_item_r.status      <= tsa_pkg::STATUS_OK;
      out_item_r.slot        <= tsa_pkg::slot_of(popped);
      out_item_r.assigned_id <= next_id_r;
    end else if (exec_free) begin
      out_item_r.status      <= tsa_pkg::STATUS_OK;
      out_item_r.slot        <= tsa_pkg::slot_of(idx_r);
      out_item_r.assigned_id <= tid_r;
    end else if (exec_fail) begin
      out_item_r.status      <= tsa_pkg::STATUS_FAIL;
      out_item_r.slot        <= '0;
      out_item_r.assigned_id <= (req_r == tsa_pkg::REQ_END) ? tid_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[verif/tb_task_slot_allocator.sv]
// Testbench for the task slot allocator: directed and random create/end traffic with a self-checking predictor.
module tb_task_slot_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import tsa_pkg::*;

  // Run bounds. The slowest correct run is roughly 1300 items, each slowed by an end miss
  // scan, the longest sender gap and long receiver stalls, so the cap is set well above.
  localparam int RANDOM_ITEMS = 1280;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_CYCLES = SLOTS + 8;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  task_slot_allocator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Slot table mirror: what the allocator should hold after each accepted item.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0] table_ids  [SLOTS];
  bit              table_live [SLOTS];
  logic [SW-1:0]   free_slots [SLOTS];   // LIFO, top at free_count - 1
  int unsigned     free_count;
  logic [ID_W-1:0] id_counter;
  logic [ID_W-1:0] last_freed_id;        // handy for "dead slot, same id" hits

  out_item_t   results_due[$];           // results owed by the block, oldest first
  int unsigned error_count;
  int unsigned cycle_count;

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      table_ids[i]  = '0;
      table_live[i] = 1'b0;
      free_slots[i] = SW'(SLOTS - 1 - i);  // pops hand out 0, 1, 2, ...
    end
    free_count    = SLOTS;
    id_counter    = '0;
    last_freed_id = '0;
  endfunction

  // Apply one request to the mirror and return the result it must produce.
  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t     res;
    logic [SW-1:0] s;
    res = '{status: STATUS_FAIL, slot: '0, assigned_id: '0};
    if (req.req_type == REQ_CREATE) begin
      // empty free list: fail, nothing changes
      if (free_count != 0) begin
        free_count--;
        s = free_slots[free_count];
        table_ids[s]  = id_counter;
        table_live[s] = 1'b1;
        res = '{status: STATUS_OK, slot: SLOT_W'(s), assigned_id: id_counter};
        id_counter++;
      end
    end else begin
      res.assigned_id = req.task_id;       // end always echoes the id
      for (int i = 0; i < SLOTS; i++) begin
        if (table_live[i] && table_ids[i] == req.task_id) begin
          table_live[i] = 1'b0;
          if (free_count < SLOTS) begin
            free_slots[free_count] = SW'(i);
            free_count++;
          end
          last_freed_id = req.task_id;
          res.status = STATUS_OK;
          res.slot   = SLOT_W'(i);
          break;
        end
      end
    end
    return res;
  endfunction

  // Random id of a live task; found = 0 when the table is empty.
  function automatic logic [ID_W-1:0] pick_live_id(output bit found);
    logic [ID_W-1:0] ids[$];
    for (int i = 0; i < SLOTS; i++)
      if (table_live[i]) ids.push_back(table_ids[i]);
    found = (ids.size() != 0);
    if (!found) return $urandom();
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Items are driven with NBAs at the rising edge; valid stays up
  // after acceptance so back-to-back items never toggle it within one step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic kind, input logic [ID_W-1:0] id);
    in_item_t req;
    req.req_type = kind;
    req.task_id  = id;
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (!in_ready);
    results_due.push_back(apply_request(req));
  endtask

  // Sender gap whose length is set by n; payload scrambled while idle.
  task automatic hold_off(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      in_item  <= {1'($urandom()), ID_W'($urandom())};
      repeat (n) @(posedge clk);
    end
  endtask

  // Pause until everything owed has come back (the loop waits on the clock before it
  // checks, so valid is never lowered and raised in the same step).
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern steps through four phases taken from the cycle counter -
  // always ready, mostly ready, mostly stalled, then a fixed on/off rhythm.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    case ((cycle_count >> 8) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 99) < 75);
      2: out_ready <= ($urandom_range(0, 99) < 25);
      default: out_ready <= ((cycle_count % 8) < 3);
    endcase
  end

  // Result checker: every accepted result against the oldest owed result.
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, actual status %0d slot %0d id %0h",
                 $time, out_item.status, out_item.slot, out_item.assigned_id);
        error_count++;
      end else begin
        exp_res = results_due.pop_front();
        if (out_item.status !== exp_res.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, exp_res.status, out_item.status);
          error_count++;
        end
        if (out_item.slot !== exp_res.slot) begin
          $display("%0t: slot mismatch, expected %0d actual %0d",
                   $time, exp_res.slot, out_item.slot);
          error_count++;
        end
        if (out_item.assigned_id !== exp_res.assigned_id) begin
          $display("%0t: assigned_id mismatch, expected %0h actual %0h",
                   $time, exp_res.assigned_id, out_item.assigned_id);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, results_due.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // End requests against an empty table: zero, all-ones and one ids all miss.
  task automatic test_end_on_empty();
    send_item(REQ_END, 32'h0000_0000);
    send_item(REQ_END, 32'hFFFF_FFFF);
    hold_off(2);
    send_item(REQ_END, 32'h0000_0001);
  endtask

  // Fill every slot (create ignores task_id, so junk goes there), then one
  // more create must fail on the empty free list.
  task automatic test_exhaust_pool();
    for (int i = 0; i < SLOTS; i++)
      send_item(REQ_CREATE, (i % 2) ? 32'hFFFF_FFFF : 32'hA5A5_5A5A);
    send_item(REQ_CREATE, 32'h0000_0000);
    drain();
  endtask

  // Freed slots come back LIFO; a dead slot still holding the id is a miss.
  task automatic test_reuse_order();
    send_item(REQ_END, 32'd7);          // last slot - longest hit scan
    send_item(REQ_END, 32'd2);
    send_item(REQ_END, 32'd2);          // same id again: slot now dead
    send_item(REQ_END, 32'd0);          // first slot
    send_item(REQ_CREATE, '0);          // expect slot 0 back first
    send_item(REQ_CREATE, '0);          // then slot 2
    send_item(REQ_CREATE, '0);          // then slot 7
    send_item(REQ_END, id_counter);     // id not yet handed out
    drain();
  endtask

  // Tear the table down so the random part starts from a mixed point.
  task automatic test_release_all();
    logic [ID_W-1:0] id;
    bit              found;
    id = pick_live_id(found);
    while (found) begin
      send_item(REQ_END, id);
      id = pick_live_id(found);
    end
  endtask

  // Random traffic in bursts. Each burst has its own create bias so the table
  // swings between full and empty; most ends name live tasks, the rest are
  // noise (random ids, freshly freed ids, the newest issued id, ids not yet issued).
  task automatic test_random_traffic(input int n_items);
    int              sent;
    int              burst;
    int              create_pct;
    int              roll;
    logic [ID_W-1:0] id;
    bit              found;
    sent = 0;
    while (sent < n_items) begin
      burst      = $urandom_range(1, 24);
      create_pct = $urandom_range(15, 85);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < create_pct) begin
          send_item(REQ_CREATE, $urandom());
        end else begin
          roll = $urandom_range(0, 99);
          id   = pick_live_id(found);
          if (roll >= 80)      id = $urandom();
          else if (roll >= 72) id = last_freed_id;
          else if (roll >= 66) id = id_counter;
          else if (roll >= 60) id = id_counter - 1;
          send_item(REQ_END, id);
        end
        sent++;
        // occasional single-cycle hiccup inside a burst
        if ($urandom_range(0, 15) == 0) hold_off(1);
      end
      if ($urandom_range(0, 24) == 0) drain();
      else if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
    end
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    in_valid    = 1'b0;
    in_item     = '0;
    out_ready   = 1'b0;
    rst_n       = 1'b0;
    clear_table();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_end_on_empty();
    test_exhaust_pool();
    test_reuse_order();
    test_release_all();
    drain();
    test_random_traffic(RANDOM_ITEMS);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
